/* rtl/core/mesm_pkg.sv */
`default_nettype none

package mesm_pkg;

   // Edge states as held in the store
   typedef enum logic [1:0] {
      EDGE_UNKNOWN = 2'd0,
      EDGE_OPEN    = 2'd1,
      EDGE_WALL    = 2'd2
   } edge_state_type;

   // Request operations
   typedef enum logic [1:0] {
      OP_QUERY       = 2'd0,
      OP_SET_WALL    = 2'd1,
      OP_SET_OPEN    = 2'd2,
      OP_SET_UNKNOWN = 2'd3
   } op_type;

   // Register indexes on the csr port
   localparam logic CSR_MAZE_WIDTH  = 1'b0;
   localparam logic CSR_MAZE_HEIGHT = 1'b1;

   localparam int COORD_W   = 8;
   localparam int SIZE_W    = 6;
   localparam int REQ_BITS  = 34;
   localparam int REQ_TDATA = 40;
   localparam int RSP_TDATA = 8;

   // Decoded request, passed from the pair checker to the core
   typedef struct packed {
      logic           pair_ok;
      logic           out_of_bounds;
      logic           do_write;
      edge_state_type wr_state;
   } pair_info_type;

endpackage

`default_nettype wire

/* rtl/core/maze_edge_state_map_core.sv */
`default_nettype none

// Channel | Dir | Handshake           | Word contents (lowest bit up)
// req     | in  | req_tvalid/tready   | operation, first_x, first_y, second_x, second_y
// rsp     | out | rsp_tvalid/tready   | pair_ok, is_wall, is_open, is_unknown
// csr     | in  | csr_we (no wait)    | index 0 maze_width, index 1 maze_height
//
// One word a cycle is taken while the store is ready and the read stage can move on;
// its response passes through the read stage and then the output register before rsp offers it.
// The edge store is a single synchronous memory with at most one access per word
// (read for a valid query, write for a valid set), which sets the rate at one word a cycle.
// After reset a clearing pass writes all 4*MAX_WIDTH*MAX_HEIGHT entries
// (4096 by default); req_tready stays low meanwhile, csr writes are taken.
// A stalled rsp holds its word; the read stage behind it holds and, once full, req_tready drops.

module maze_edge_state_map_core #(
   parameter int MAX_WIDTH  = 32,
   parameter int MAX_HEIGHT = 32
) (
   input  var logic                              clock,
   input  var logic                              reset,
   // req
   input  var logic                              req_tvalid,
   output logic                                  req_tready,
   // operation[1:0], first_x[9:2], first_y[17:10], second_x[25:18],
   // second_y[33:26], zero fill above
   input  var logic [mesm_pkg::REQ_TDATA-1:0]    req_tdata,
   // rsp
   output logic                                  rsp_tvalid,
   input  var logic                              rsp_tready,
   // pair_ok[0], is_wall[1], is_open[2], is_unknown[3], zero fill above
   output logic [mesm_pkg::RSP_TDATA-1:0]        rsp_tdata,
   // csr
   input  var logic                              csr_we,
   input  var logic                              csr_index,
   input  var logic [mesm_pkg::SIZE_W-1:0]       csr_wdata
);

   localparam int DEPTH  = 4 * MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   // Configuration registers
   logic [mesm_pkg::SIZE_W-1:0] maze_width_ff;
   logic [mesm_pkg::SIZE_W-1:0] maze_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         maze_width_ff  <= mesm_pkg::SIZE_W'(32);
         maze_height_ff <= mesm_pkg::SIZE_W'(32);
      end else if (csr_we) begin
         unique case (csr_index)
            mesm_pkg::CSR_MAZE_WIDTH:  maze_width_ff  <= csr_wdata;
            mesm_pkg::CSR_MAZE_HEIGHT: maze_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Decode the incoming word
   mesm_pkg::pair_info_type info;
   logic [ADDR_W-1:0]       addr;

   mesm_check #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_W     (ADDR_W)
   ) u_check (
      .operation   (mesm_pkg::op_type'(req_tdata[1:0])),
      .first_x     (req_tdata[9:2]),
      .first_y     (req_tdata[17:10]),
      .second_x    (req_tdata[25:18]),
      .second_y    (req_tdata[33:26]),
      .maze_width  (maze_width_ff),
      .maze_height (maze_height_ff),
      .info        (info),
      .addr        (addr)
   );

   // Handshake: advance the read stage only when the output slot frees up
   logic store_ready;
   logic req_acc;
   logic out_free;
   logic s1_valid_ff;
   logic s1_valid_in;
   mesm_pkg::pair_info_type s1_info_ff;

   assign out_free   = !rsp_tvalid || rsp_tready;
   assign req_tready = store_ready && (!s1_valid_ff || out_free);
   assign req_acc    = req_tvalid && req_tready;

   // Sets write straight away; queries read and pick up the data next cycle
   mesm_pkg::edge_state_type rd_data;

   mesm_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_acc && info.pair_ok && !info.do_write),
      .wr_en   (req_acc && info.do_write),
      .addr    (addr),
      .wr_data (info.wr_state),
      .rd_data (rd_data),
      .ready   (store_ready)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_info_ff <= info;
      end
   end

   // Form the flags: a set reports the value just written
   mesm_pkg::edge_state_type st;
   logic [3:0]               flags;

   assign st = s1_info_ff.do_write ? s1_info_ff.wr_state : rd_data;

   always_comb begin
      flags[0] = s1_info_ff.pair_ok;
      flags[1] = s1_info_ff.out_of_bounds ||
                 (s1_info_ff.pair_ok && (st == mesm_pkg::EDGE_WALL));
      flags[2] = s1_info_ff.pair_ok && (st == mesm_pkg::EDGE_OPEN);
      flags[3] = s1_info_ff.pair_ok && (st == mesm_pkg::EDGE_UNKNOWN);
   end

   // Output register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [3:0] rsp_flags_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_flags_ff <= flags;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_flags_ff};

   // Checks

   // A stalled read stage keeps its word
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_info_ff)))
      else $error("read stage lost or changed a stalled word");

   // An accepted word always lands in the read stage
   a_acc_lands: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> s1_valid_ff)
      else $error("accepted word did not reach the read stage");

   // A valid pair reports exactly one edge state
   a_one_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> $onehot(rsp_tdata[3:1]))
      else $error("valid pair with no single edge state");

   // Nothing is taken while the clearing pass runs
   a_no_acc_clear: assert property (@(posedge clock) disable iff (reset)
      !store_ready |-> !req_acc)
      else $error("word accepted during clearing pass");

endmodule

`default_nettype wire

/* rtl/core/mesm_check.sv */
`default_nettype none

module mesm_check #(
   parameter int MAX_WIDTH  = 32,
   parameter int MAX_HEIGHT = 32,
   parameter int ADDR_W     = 12
) (
   input  var mesm_pkg::op_type                       operation,
   input  var logic signed [mesm_pkg::COORD_W-1:0]    first_x,
   input  var logic signed [mesm_pkg::COORD_W-1:0]    first_y,
   input  var logic signed [mesm_pkg::COORD_W-1:0]    second_x,
   input  var logic signed [mesm_pkg::COORD_W-1:0]    second_y,
   input  var logic        [mesm_pkg::SIZE_W-1:0]     maze_width,
   input  var logic        [mesm_pkg::SIZE_W-1:0]     maze_height,
   output mesm_pkg::pair_info_type                    info,
   output logic            [ADDR_W-1:0]               addr
);

   localparam logic [7:0] MAX_W8    = 8'(MAX_WIDTH);
   localparam logic [7:0] MAX_H8    = 8'(MAX_HEIGHT);
   localparam int         DATA_ROWS = 2 * MAX_HEIGHT;

   logic [7:0]       w_eff;
   logic [7:0]       h_eff;
   logic             first_in;
   logic             second_in;
   logic signed [8:0] dx;
   logic signed [8:0] dy;
   logic             cardinal;
   logic [7:0]       col;
   logic [7:0]       row;

   // Saturate the configured size at the built maximum
   assign w_eff = ({2'b00, maze_width} > MAX_W8) ? MAX_W8 : {2'b00, maze_width};
   assign h_eff = ({2'b00, maze_height} > MAX_H8) ? MAX_H8 : {2'b00, maze_height};

   assign first_in  = !first_x[7] && !first_y[7] &&
                      (8'(first_x) < w_eff) && (8'(first_y) < h_eff);
   assign second_in = !second_x[7] && !second_y[7] &&
                      (8'(second_x) < w_eff) && (8'(second_y) < h_eff);

   assign dx = 9'(second_x) - 9'(first_x);
   assign dy = 9'(second_y) - 9'(first_y);
   assign cardinal = ((dx == 9'sd0) && ((dy == 9'sd1) || (dy == -9'sd1))) ||
                     ((dy == 9'sd0) && ((dx == 9'sd1) || (dx == -9'sd1)));

   // 2*second - diff equals the sum of both coordinates
   assign col  = 8'(first_x) + 8'(second_x);
   assign row  = 8'(first_y) + 8'(second_y);
   assign addr = ADDR_W'(col) * ADDR_W'(DATA_ROWS) + ADDR_W'(row);

   always_comb begin
      info.out_of_bounds = !(first_in && second_in);
      info.pair_ok       = first_in && second_in && cardinal;
      info.do_write      = 1'b0;
      info.wr_state      = mesm_pkg::EDGE_UNKNOWN;
      unique case (operation)
         mesm_pkg::OP_QUERY: begin
            info.do_write = 1'b0;
         end
         mesm_pkg::OP_SET_WALL: begin
            info.do_write = info.pair_ok;
            info.wr_state = mesm_pkg::EDGE_WALL;
         end
         mesm_pkg::OP_SET_OPEN: begin
            info.do_write = info.pair_ok;
            info.wr_state = mesm_pkg::EDGE_OPEN;
         end
         mesm_pkg::OP_SET_UNKNOWN: begin
            info.do_write = info.pair_ok;
            info.wr_state = mesm_pkg::EDGE_UNKNOWN;
         end
         default: begin
            info.do_write = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/mesm_store.sv */
`default_nettype none

module mesm_store #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  var logic                         clock,
   input  var logic                         reset,
   input  var logic                         rd_en,
   input  var logic                         wr_en,
   input  var logic [ADDR_W-1:0]            addr,
   input  var mesm_pkg::edge_state_type     wr_data,
   output mesm_pkg::edge_state_type         rd_data,
   output logic                             ready
);

   mesm_pkg::edge_state_type mem [DEPTH];
   mesm_pkg::edge_state_type rd_data_ff;

   logic              clr_busy_ff;
   logic              clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;

   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_waddr;
   mesm_pkg::edge_state_type mem_wdata;

   // Sweep every entry to unknown after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign mem_we    = clr_busy_ff || wr_en;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : addr;
   assign mem_wdata = clr_busy_ff ? mesm_pkg::EDGE_UNKNOWN : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clr_busy_ff;

endmodule

`default_nettype wire
